// ===== rtl/ppusar_pkg.sv =====
// shared types and constants for the scroll and address register unit
package ppusar_pkg;

    localparam int SPRITE_MEM_DEPTH = 256;
    localparam int OAM_AW = $clog2(SPRITE_MEM_DEPTH);
    localparam int VADDR_W = 15;

    typedef enum logic [2:0] {
        OP_BUS_WRITE  = 3'd0,
        OP_BUS_READ   = 3'd1,
        OP_PIXEL_TICK = 3'd2,
        OP_COPY_HORIZ = 3'd3,
        OP_COPY_VERT  = 3'd4,
        OP_VBLANK_SET = 3'd5,
        OP_PRERENDER  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        REG_CONTROL  = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDRESS  = 3'd6,
        REG_DATA     = 3'd7
    } reg_sel_t;

    typedef struct packed {
        op_t          op;
        reg_sel_t     reg_sel;
        logic [7:0]   wdata;
    } item_t;

    typedef struct packed {
        logic [7:0]         rdata;
        logic [VADDR_W-1:0] vram_addr;
        logic               vram_write;
        logic               vram_read;
        logic [7:0]         vram_wdata;
        logic [2:0]         fine_scroll_x;
        logic               nmi;
    } result_t;

endpackage

// ===== rtl/ppu_scroll_address_registers.sv =====
// top level of the scroll and address register unit
// a transaction passes the input register, then ppusar_core and the result register
// throughput: one transaction per cycle while the consumer holds out_ready high
// while a result waits the input register takes one more transaction, then in_ready drops
// reset clears all control, scroll and address registers and both valid flags
// sprite memory contents are undefined after reset until written
module ppu_scroll_address_registers
    import ppusar_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [2:0]   op,
    input  logic [2:0]   reg_sel,
    input  logic [7:0]   wdata,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   rdata,
    output logic [14:0]  vram_addr,
    output logic         vram_write,
    output logic         vram_read,
    output logic [7:0]   vram_wdata,
    output logic [2:0]   fine_scroll_x,
    output logic         nmi
);

    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    advance;
    result_t core_result;
    result_t result_out;

    assign advance = item_valid && out_free;

    ppusar_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .reg_sel    (reg_sel),
        .wdata      (wdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ppusar_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (core_result)
    );

    ppusar_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (core_result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign rdata         = result_out.rdata;
    assign vram_addr     = result_out.vram_addr;
    assign vram_write    = result_out.vram_write;
    assign vram_read     = result_out.vram_read;
    assign vram_wdata    = result_out.vram_wdata;
    assign fine_scroll_x = result_out.fine_scroll_x;
    assign nmi           = result_out.nmi;

endmodule

// ===== rtl/ppusar_in_stage.sv =====
// input register stage holding one accepted bus or render transaction
module ppusar_in_stage
    import ppusar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [2:0] reg_sel,
    input  logic [7:0] wdata,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    logic  load;
    item_t item_reg;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.op      <= op_t'(op);
            item_reg.reg_sel <= reg_sel_t'(reg_sel);
            item_reg.wdata   <= wdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/ppusar_core.sv =====
// register file, scroll address stepping and sprite memory
module ppusar_core
    import ppusar_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    logic [7:0]         control_reg;
    logic [7:0]         control_next;
    logic [7:0]         mask_reg;
    logic [7:0]         mask_next;
    logic [VADDR_W-1:0] cur_addr_reg;
    logic [VADDR_W-1:0] cur_addr_next;
    logic [VADDR_W-1:0] temp_addr_reg;
    logic [VADDR_W-1:0] temp_addr_next;
    logic [2:0]         fine_x_reg;
    logic [2:0]         fine_x_next;
    logic               toggle_reg;
    logic               toggle_next;
    logic               vblank_reg;
    logic               vblank_next;
    logic [OAM_AW-1:0]  oam_addr_reg;
    logic [OAM_AW-1:0]  oam_addr_next;
    logic [7:0]         oam_rdata_reg;
    logic               oam_we;
    logic               rendering;
    logic [VADDR_W-1:0] data_step_addr;
    logic [7:0]         sprite_mem [SPRITE_MEM_DEPTH];

    function automatic logic [VADDR_W-1:0] step_tile(input logic [VADDR_W-1:0] v);
        logic [VADDR_W-1:0] r;
        r = v;
        if (v[4:0] != 5'd31)
        begin
            r[4:0] = v[4:0] + 5'd1;
        end
        else
        begin
            r[4:0] = 5'd0;
            r[10]  = ~v[10];
            if (v[14:12] != 3'd7)
            begin
                r[14:12] = v[14:12] + 3'd1;
            end
            else
            begin
                r[14:12] = 3'd0;
                priority if (v[9:5] == 5'd29)
                begin
                    // bottom of the visible rows: switch vertical nametable
                    r[9:5] = 5'd0;
                    r[11]  = ~v[11];
                end
                else if (v[9:5] == 5'd31)
                begin
                    r[9:5] = 5'd0;
                end
                else
                begin
                    r[9:5] = v[9:5] + 5'd1;
                end
            end
        end
        return r;
    endfunction

    assign rendering      = mask_reg[3] || mask_reg[4];
    assign data_step_addr = control_reg[2] ? cur_addr_reg + VADDR_W'(32)
                                           : cur_addr_reg + VADDR_W'(1);

    always_comb
    begin
        control_next   = control_reg;
        mask_next      = mask_reg;
        cur_addr_next  = cur_addr_reg;
        temp_addr_next = temp_addr_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        vblank_next    = vblank_reg;
        oam_addr_next  = oam_addr_reg;
        oam_we         = 1'b0;

        result.rdata         = 8'd0;
        result.vram_addr     = cur_addr_reg;
        result.vram_write    = 1'b0;
        result.vram_read     = 1'b0;
        result.vram_wdata    = 8'd0;
        result.nmi           = 1'b0;

        if (fire)
        begin
            unique case (item.op)
                OP_BUS_WRITE:
                begin
                    unique case (item.reg_sel)
                        REG_CONTROL:
                        begin
                            control_next          = item.wdata;
                            temp_addr_next[11:10] = item.wdata[1:0];
                        end
                        REG_MASK:
                        begin
                            mask_next = item.wdata;
                        end
                        REG_STATUS:
                        begin
                        end
                        REG_OAM_ADDR:
                        begin
                            oam_addr_next = item.wdata;
                        end
                        REG_OAM_DATA:
                        begin
                            oam_we        = 1'b1;
                            oam_addr_next = oam_addr_reg + OAM_AW'(1);
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_addr_next[4:0] = item.wdata[7:3];
                                fine_x_next         = item.wdata[2:0];
                            end
                            else
                            begin
                                temp_addr_next[9:5]   = item.wdata[7:3];
                                temp_addr_next[14:12] = item.wdata[2:0];
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_ADDRESS:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_addr_next = {1'b0, item.wdata[5:0], temp_addr_reg[7:0]};
                            end
                            else
                            begin
                                temp_addr_next = {temp_addr_reg[14:8], item.wdata};
                                cur_addr_next  = {temp_addr_reg[14:8], item.wdata};
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_DATA:
                        begin
                            result.vram_write = 1'b1;
                            result.vram_wdata = item.wdata;
                            cur_addr_next     = data_step_addr;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_BUS_READ:
                begin
                    priority if (item.reg_sel == REG_STATUS)
                    begin
                        result.rdata = {vblank_reg, 7'd0};
                        vblank_next  = 1'b0;
                        toggle_next  = 1'b0;
                    end
                    else if (item.reg_sel == REG_OAM_DATA)
                    begin
                        result.rdata = oam_rdata_reg;
                    end
                    else if (item.reg_sel == REG_DATA)
                    begin
                        result.vram_read = 1'b1;
                        cur_addr_next    = data_step_addr;
                    end
                    else
                    begin
                    end
                end
                OP_PIXEL_TICK:
                begin
                    if (rendering)
                    begin
                        if (fine_x_reg == 3'd7)
                        begin
                            fine_x_next   = 3'd0;
                            cur_addr_next = step_tile(cur_addr_reg);
                        end
                        else
                        begin
                            fine_x_next = fine_x_reg + 3'd1;
                        end
                    end
                end
                OP_COPY_HORIZ:
                begin
                    if (rendering)
                    begin
                        cur_addr_next[10]  = temp_addr_reg[10];
                        cur_addr_next[4:0] = temp_addr_reg[4:0];
                    end
                end
                OP_COPY_VERT:
                begin
                    if (rendering)
                    begin
                        cur_addr_next[14:11] = temp_addr_reg[14:11];
                        cur_addr_next[9:5]   = temp_addr_reg[9:5];
                    end
                end
                OP_VBLANK_SET:
                begin
                    vblank_next = 1'b1;
                    result.nmi  = control_reg[7];
                end
                OP_PRERENDER:
                begin
                    vblank_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        result.fine_scroll_x = fine_x_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            mask_reg      <= '0;
            cur_addr_reg  <= '0;
            temp_addr_reg <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            vblank_reg    <= 1'b0;
            oam_addr_reg  <= '0;
        end
        else
        begin
            control_reg   <= control_next;
            mask_reg      <= mask_next;
            cur_addr_reg  <= cur_addr_next;
            temp_addr_reg <= temp_addr_next;
            fine_x_reg    <= fine_x_next;
            toggle_reg    <= toggle_next;
            vblank_reg    <= vblank_next;
            oam_addr_reg  <= oam_addr_next;
        end
    end

    // read port follows the next oam address; a write always moves the address
    // away from the written entry, so the read never collides with it
    always_ff @(posedge clk)
    begin
        if (oam_we)
        begin
            sprite_mem[oam_addr_reg] <= item.wdata;
        end
        oam_rdata_reg <= sprite_mem[oam_addr_next];
    end

endmodule

// ===== rtl/ppusar_out_stage.sv =====
// result register with valid and ready toward the consumer
module ppusar_out_stage
    import ppusar_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== rtl/ppusar_checker.sv =====
// port-level checks for the scroll and address register unit
module ppusar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  op,
    input logic [2:0]  reg_sel,
    input logic [7:0]  wdata,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  rdata,
    input logic [14:0] vram_addr,
    input logic        vram_write,
    input logic        vram_read,
    input logic [7:0]  vram_wdata,
    input logic [2:0]  fine_scroll_x,
    input logic        nmi
);

    // a waiting input transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op) && $stable(reg_sel)
            && $stable(wdata))
    else $error("waiting input transaction changed");

    // a stalled result keeps its address and strobes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vram_addr) && $stable(vram_write)
            && $stable(vram_read) && $stable(fine_scroll_x))
    else $error("stalled result changed");

    // a data-port transaction is either a write or a read, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(vram_write && vram_read))
    else $error("both video strobes set");

    // write data only appears with a video write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vram_write |-> vram_wdata == 8'd0)
    else $error("write data without write strobe");

    // nmi comes from a render event, never from a bus transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && nmi |-> !vram_write && !vram_read && rdata == 8'd0)
    else $error("nmi together with bus result");

endmodule

bind ppu_scroll_address_registers ppusar_checker u_checker (.*);

// ===== tb/ppu_scroll_address_registers_tb.sv =====
// testbench for the scroll and address register unit: directed and random traffic, self-checking
module ppu_scroll_address_registers_tb
    import ppusar_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1050;
    localparam logic [2:0] OP_NONE = 3'd7;

    typedef struct {
        logic [2:0] op;
        logic [2:0] sel;
        logic [7:0] wd;
        bit         pause;
    } bus_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = 3'd0;
    logic [2:0]  reg_sel = 3'd0;
    logic [7:0]  wdata = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  rdata;
    logic [14:0] vram_addr;
    logic        vram_write;
    logic        vram_read;
    logic [7:0]  vram_wdata;
    logic [2:0]  fine_scroll_x;
    logic        nmi;

    // register copies kept in step with the unit
    logic [7:0]  r_ctrl = '0;
    logic [7:0]  r_mask = '0;
    logic [14:0] r_v = '0;
    logic [14:0] r_t = '0;
    logic [3:0]  r_fx = '0;
    logic        r_w = 1'b0;
    logic        r_vbl = 1'b0;
    logic [7:0]  r_oam_ptr = '0;
    logic [7:0]  r_oam [SPRITE_MEM_DEPTH];

    // stimulus side view of the oam pointer, so that unwritten entries are never read
    logic [7:0]  gen_ptr = '0;
    bit          gen_written [SPRITE_MEM_DEPTH];
    int          gen_count = 0;

    bus_cmd_t    bus_cmds[$];
    result_t     awaited_out[$];

    bit          in_fire = 1'b0;
    bit          draining = 1'b0;
    bit          calm = 1'b0;
    int          hold_cycles = 0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          fail_count = 0;
    int          tile_steps = 0;
    int          nmi_count = 0;

    ppu_scroll_address_registers uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .reg_sel(reg_sel),
        .wdata(wdata),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .rdata(rdata),
        .vram_addr(vram_addr),
        .vram_write(vram_write),
        .vram_read(vram_read),
        .vram_wdata(vram_wdata),
        .fine_scroll_x(fine_scroll_x),
        .nmi(nmi)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // coarse x, then fine y, coarse y and the nametable bits
    function automatic logic [14:0] next_tile(logic [14:0] a);
        logic [14:0] v;
        v = a;
        if (v[4:0] != 5'd31)
            v[4:0] = v[4:0] + 5'd1;
        else
        begin
            v[4:0] = 5'd0;
            v[10] = ~v[10];
            if (v[14:12] != 3'd7)
                v[14:12] = v[14:12] + 3'd1;
            else
            begin
                v[14:12] = 3'd0;
                if (v[9:5] == 5'd29)
                begin
                    v[9:5] = 5'd0;
                    v[11] = ~v[11];
                end
                else if (v[9:5] == 5'd31)
                    v[9:5] = 5'd0;
                else
                    v[9:5] = v[9:5] + 5'd1;
            end
        end
        return v;
    endfunction

    function automatic result_t step_registers(logic [2:0] o, logic [2:0] s, logic [7:0] d);
        result_t r;
        r = '0;
        r.vram_addr = r_v;
        case (o)
            OP_BUS_WRITE:
                case (s)
                    REG_CONTROL:
                    begin
                        r_ctrl = d;
                        r_t[11:10] = d[1:0];
                    end
                    REG_MASK:     r_mask = d;
                    REG_OAM_ADDR: r_oam_ptr = d;
                    REG_OAM_DATA:
                    begin
                        r_oam[r_oam_ptr] = d;
                        r_oam_ptr = r_oam_ptr + 8'd1;
                    end
                    REG_SCROLL:
                        if (!r_w)
                        begin
                            r_t[4:0] = d[7:3];
                            r_fx = {1'b0, d[2:0]};
                            r_w = 1'b1;
                        end
                        else
                        begin
                            r_t[14:12] = d[2:0];
                            r_t[9:5] = d[7:3];
                            r_w = 1'b0;
                        end
                    REG_ADDRESS:
                        if (!r_w)
                        begin
                            r_t[14:8] = {1'b0, d[5:0]};
                            r_w = 1'b1;
                        end
                        else
                        begin
                            r_t[7:0] = d;
                            r_v = r_t;
                            r_w = 1'b0;
                        end
                    REG_DATA:
                    begin
                        r.vram_write = 1'b1;
                        r.vram_wdata = d;
                        r_v = r_v + (r_ctrl[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            OP_BUS_READ:
                case (s)
                    REG_STATUS:
                    begin
                        r.rdata = {r_vbl, 7'd0};
                        r_vbl = 1'b0;
                        r_w = 1'b0;
                    end
                    REG_OAM_DATA: r.rdata = r_oam[r_oam_ptr];
                    REG_DATA:
                    begin
                        r.vram_read = 1'b1;
                        r_v = r_v + (r_ctrl[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            OP_PIXEL_TICK:
                if (r_mask[3] || r_mask[4])
                begin
                    r_fx = r_fx + 4'd1;
                    if (r_fx >= 4'd8)
                    begin
                        r_fx = 4'd0;
                        r_v = next_tile(r_v);
                        tile_steps++;
                    end
                end
            OP_COPY_HORIZ:
                if (r_mask[3] || r_mask[4])
                begin
                    r_v[10] = r_t[10];
                    r_v[4:0] = r_t[4:0];
                end
            OP_COPY_VERT:
                if (r_mask[3] || r_mask[4])
                begin
                    r_v[14:11] = r_t[14:11];
                    r_v[9:5] = r_t[9:5];
                end
            OP_VBLANK_SET:
            begin
                r_vbl = 1'b1;
                r.nmi = r_ctrl[7];
                if (r_ctrl[7])
                    nmi_count++;
            end
            OP_PRERENDER: r_vbl = 1'b0;
            default: ;
        endcase
        r.fine_scroll_x = r_fx[2:0];
        return r;
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_cmd(logic [2:0] o, logic [2:0] s, logic [7:0] d);
        bus_cmd_t c;
        if (o == OP_BUS_READ && s == REG_OAM_DATA && !gen_written[gen_ptr])
            o = OP_BUS_WRITE;
        if (o == OP_BUS_WRITE && s == REG_OAM_ADDR)
            gen_ptr = d;
        else if (o == OP_BUS_WRITE && s == REG_OAM_DATA)
        begin
            gen_written[gen_ptr] = 1'b1;
            gen_ptr = gen_ptr + 8'd1;
        end
        c.op = o;
        c.sel = s;
        c.wd = d;
        c.pause = 1'b0;
        bus_cmds.push_back(c);
        gen_count++;
    endtask

    task automatic add_pause();
        bus_cmd_t c;
        c.op = OP_NONE;
        c.sel = REG_CONTROL;
        c.wd = 8'd0;
        c.pause = 1'b1;
        bus_cmds.push_back(c);
    endtask

    task automatic add_mask_on();
        add_cmd(OP_BUS_WRITE, REG_MASK, 8'($urandom) | ($urandom_range(0, 1) ? 8'h08 : 8'h10));
    endtask

    task automatic add_ticks(int n);
        repeat (n) add_cmd(OP_PIXEL_TICK, 3'($urandom), 8'($urandom));
    endtask

    task automatic add_data_burst(int n);
        repeat (n) add_cmd($urandom_range(0, 1) ? OP_BUS_WRITE : OP_BUS_READ, REG_DATA,
                           8'($urandom));
    endtask

    function automatic int compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // input side acceptance and result checking
    always @(posedge clk)
    begin
        result_t want;
        int errs;
        if (rst_n && in_valid && in_ready)
        begin
            awaited_out.push_back(step_registers(op, reg_sel, wdata));
            in_fire = 1'b1;
            sent_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_out.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, vram_addr %0h rdata %0h",
                         $time, vram_addr, rdata);
                fail_count++;
            end
            else
            begin
                want = awaited_out[0];
                awaited_out.delete(0);
                errs = compare_field("rdata", 16'(want.rdata), 16'(rdata))
                     + compare_field("vram_addr", 16'(want.vram_addr), 16'(vram_addr))
                     + compare_field("vram_write", 16'(want.vram_write), 16'(vram_write))
                     + compare_field("vram_read", 16'(want.vram_read), 16'(vram_read))
                     + compare_field("vram_wdata", 16'(want.vram_wdata), 16'(vram_wdata))
                     + compare_field("fine_scroll_x", 16'(want.fine_scroll_x),
                                     16'(fine_scroll_x))
                     + compare_field("nmi", 16'(want.nmi), 16'(nmi));
                if (errs != 0)
                    fail_count++;
                checked_count++;
            end
        end
    end

    // driver: next transaction once the current one is taken
    always @(negedge clk)
    begin
        bus_cmd_t c;
        if (rst_n && (!in_valid || in_fire))
        begin
            in_fire = 1'b0;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                in_valid <= 1'b0;
            end
            else if (draining)
            begin
                in_valid <= 1'b0;
                if (awaited_out.size() == 0)
                    draining = 1'b0;
            end
            else if (bus_cmds.size() > 0)
            begin
                c = bus_cmds[0];
                bus_cmds.delete(0);
                if (c.pause)
                begin
                    draining = 1'b1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    op <= c.op;
                    reg_sel <= c.sel;
                    wdata <= c.wd;
                    if ($urandom_range(0, 199) == 0)
                        calm = !calm;
                    hold_cycles = pick_gap();
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_out.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int kind;
        logic [4:0] cx;
        logic [4:0] cy;
        logic [2:0] fy;

        // directed: reset values, vblank and nmi, ignored accesses, field extremes
        add_cmd(OP_BUS_READ, REG_STATUS, 8'h00);
        add_cmd(OP_PIXEL_TICK, REG_CONTROL, 8'h00);
        add_cmd(OP_COPY_HORIZ, REG_CONTROL, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_CONTROL, 8'hFF);
        add_cmd(OP_VBLANK_SET, REG_CONTROL, 8'h00);
        add_cmd(OP_BUS_READ, REG_STATUS, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_CONTROL, 8'h00);
        add_cmd(OP_VBLANK_SET, REG_DATA, 8'hFF);
        add_cmd(OP_PRERENDER, REG_DATA, 8'hFF);
        add_cmd(OP_BUS_READ, REG_STATUS, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_STATUS, 8'hFF);
        add_cmd(OP_BUS_READ, REG_CONTROL, 8'h00);
        add_cmd(OP_BUS_READ, REG_SCROLL, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_MASK, 8'h08);
        add_cmd(OP_BUS_WRITE, REG_SCROLL, 8'hFF);
        add_cmd(OP_BUS_WRITE, REG_SCROLL, 8'hFF);
        add_cmd(OP_BUS_WRITE, REG_ADDRESS, 8'hFF);
        add_cmd(OP_BUS_WRITE, REG_ADDRESS, 8'hFF);
        add_cmd(OP_PIXEL_TICK, REG_DATA, 8'hFF);
        add_cmd(OP_COPY_VERT, REG_CONTROL, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_DATA, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_CONTROL, 8'h04);
        add_cmd(OP_BUS_WRITE, REG_DATA, 8'hFF);
        add_cmd(OP_BUS_READ, REG_DATA, 8'h00);
        add_cmd(OP_BUS_WRITE, REG_OAM_ADDR, 8'hFF);
        add_cmd(OP_BUS_WRITE, REG_OAM_DATA, 8'hA5);
        add_cmd(OP_BUS_WRITE, REG_OAM_ADDR, 8'hFF);
        add_cmd(OP_BUS_READ, REG_OAM_DATA, 8'h00);
        add_cmd(OP_NONE, REG_DATA, 8'hFF);
        add_cmd(OP_BUS_WRITE, REG_MASK, 8'h10);
        add_cmd(OP_PIXEL_TICK, REG_CONTROL, 8'h00);
        add_pause();

        while (gen_count < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                // frame setup: status read, scroll pair, mask on, copies, a run of pixel ticks, sometimes a data burst
                cx = $urandom_range(0, 1) ? 5'd31 : 5'($urandom);
                fy = $urandom_range(0, 1) ? 3'd7 : 3'($urandom);
                case ($urandom_range(0, 3))
                    0: cy = 5'd29;
                    1: cy = 5'd30;
                    2: cy = 5'd31;
                    default: cy = 5'($urandom);
                endcase
                add_cmd(OP_BUS_READ, REG_STATUS, 8'($urandom));
                add_cmd(OP_BUS_WRITE, REG_SCROLL, {cx, 3'($urandom)});
                add_cmd(OP_BUS_WRITE, REG_SCROLL, {cy, fy});
                add_mask_on();
                add_cmd(OP_COPY_HORIZ, 3'($urandom), 8'($urandom));
                add_cmd(OP_COPY_VERT, 3'($urandom), 8'($urandom));
                add_ticks($urandom_range(8, 40));
                if ($urandom_range(0, 2) == 0)
                    add_data_burst($urandom_range(1, 6));
            end
            else if (kind < 42)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_mask_on();
                add_ticks($urandom_range(1, 24));
            end
            else if (kind < 56)
            begin
                add_cmd(OP_BUS_READ, REG_STATUS, 8'($urandom));
                if ($urandom_range(0, 2) == 0)
                    add_cmd(OP_BUS_WRITE, REG_CONTROL, 8'($urandom));
                add_cmd(OP_BUS_WRITE, REG_ADDRESS, 8'($urandom));
                add_cmd(OP_BUS_WRITE, REG_ADDRESS, 8'($urandom));
                add_data_burst($urandom_range(1, 6));
            end
            else if (kind < 66)
            begin
                add_cmd(OP_BUS_WRITE, REG_OAM_ADDR, 8'($urandom));
                repeat ($urandom_range(1, 4))
                    add_cmd(OP_BUS_WRITE, REG_OAM_DATA, 8'($urandom));
                repeat ($urandom_range(0, 3))
                    add_cmd(OP_BUS_READ, REG_OAM_DATA, 8'($urandom));
            end
            else if (kind < 72)
                add_cmd(OP_BUS_WRITE, REG_CONTROL, 8'($urandom));
            else if (kind < 78)
            begin
                add_cmd(OP_VBLANK_SET, 3'($urandom), 8'($urandom));
                if ($urandom_range(0, 1))
                    add_cmd(OP_BUS_READ, REG_STATUS, 8'($urandom));
                else
                    add_cmd(OP_PRERENDER, 3'($urandom), 8'($urandom));
            end
            else if (kind < 84)
                // half of a scroll or address pair flips the toggle
                add_cmd(OP_BUS_WRITE, $urandom_range(0, 1) ? REG_SCROLL : REG_ADDRESS,
                        8'($urandom));
            else if (kind < 86)
                add_cmd(OP_NONE, 3'($urandom), 8'($urandom));
            else if (kind < 87)
                add_pause();
            else
                add_cmd(3'($urandom), 3'($urandom), 8'($urandom));
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (bus_cmds.size() != 0 || in_valid || draining)
            @(posedge clk);
        while (awaited_out.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d transactions through the unit, %0d results checked field by field",
                 sent_count, checked_count);
        $display("%0d tile steps from pixel ticks, %0d nmi pulses", tile_steps, nmi_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ppusar_pkg.sv
rtl/ppusar_in_stage.sv
rtl/ppusar_core.sv
rtl/ppusar_out_stage.sv
rtl/ppu_scroll_address_registers.sv
rtl/ppusar_checker.sv
tb/ppu_scroll_address_registers_tb.sv
